>>> sv/ffha_pkg.sv
// Shared types and constants for the first-fit heap allocator.
`timescale 1ns / 1ps
`default_nettype none
package ffha_pkg;

	localparam int OFF_W  = 24;
	localparam int REQ_W  = 24;
	localparam int ADDR_W = 32;
	localparam int STAT_W = 2;
	localparam int SIZE_W = 26;

	localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
	localparam logic [STAT_W-1:0] STAT_NOMEM   = 2'd1;
	localparam logic [STAT_W-1:0] STAT_UNKNOWN = 2'd2;
	localparam logic [STAT_W-1:0] STAT_NULL    = 2'd3;

	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_A_CHK,
		ST_A_POP,
		ST_A_SPL,
		ST_A_FIN,
		ST_F_CHK,
		ST_M_HEAD,
		ST_M_CUR,
		ST_M_NXT
	} ffha_state_t;

endpackage
`default_nettype wire

>>> sv/ffha_ram.sv
// Single-port-write, single-port-read memory with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module ffha_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

>>> sv/first_fit_heap_allocator.sv
// Top level: first-fit heap allocator over an address-ordered block table.
// An allocate walks the entries through the single table read port; on a split it first pops
// a merged slot when one is free, then writes the spare block and the allocated one. A free
// walks the entries too and on a hit runs a merge pass along the chain links; a null free is
// done next cycle. One transaction at a time, busy until done is raised.
// Reset leaves one free block over the whole heap; no clearing pass; results cannot stall.
`timescale 1ns / 1ps
`default_nettype none
module first_fit_heap_allocator #(
	parameter int          HEAP_BYTES   = 16777216,
	parameter logic [31:0] HEAP_BASE    = 32'h0100_0000,
	parameter int          MAX_BLOCKS   = 64,
	parameter int          HEADER_BYTES = 24
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic                         kind,
	input  wire logic [ffha_pkg::REQ_W-1:0]   request_bytes,
	input  wire logic [ffha_pkg::ADDR_W-1:0]  free_address,
	output logic                              done,
	output logic      [ffha_pkg::STAT_W-1:0]  status,
	output logic      [ffha_pkg::ADDR_W-1:0]  payload_address
);
	import ffha_pkg::*;

	localparam int SW = $clog2(MAX_BLOCKS);
	localparam int LW = $clog2(MAX_BLOCKS + 1);
	localparam int GW = $clog2(2 * MAX_BLOCKS + 1);
	localparam int EW = OFF_W + OFF_W + 1 + LW;
	localparam logic [LW-1:0]    NULL_LINK = LW'(MAX_BLOCKS);
	localparam logic [GW-1:0]    WALK_LIM  = GW'(MAX_BLOCKS);
	localparam logic [GW-1:0]    MRG_LIM   = GW'(2 * MAX_BLOCKS);
	localparam logic [OFF_W-1:0] HDR       = OFF_W'(HEADER_BYTES);
	localparam logic [OFF_W-1:0] HEAD_SZ   = OFF_W'(HEAP_BYTES - HEADER_BYTES);
	localparam logic [SIZE_W-1:0] HDR_S    = SIZE_W'(HEADER_BYTES);

	ffha_state_t state_q, state_d;

	logic [SIZE_W-1:0] size_q, split_q;
	logic [ADDR_W-1:0] addr_q;
	logic [SW-1:0]     cur_q, ns_q;
	logic [GW-1:0]     guard_q;
	logic [LW-1:0]     sp_q, next_new_q;
	logic              head_valid_q, rd_head_q;
	logic [OFF_W-1:0]  e_off_q, e_bytes_q;
	logic              e_free_q;
	logic [LW-1:0]     e_link_q;

	logic              tbl_we;
	logic [SW-1:0]     tbl_waddr, tbl_raddr;
	logic [OFF_W-1:0]  wr_off, wr_bytes;
	logic              wr_free;
	logic [LW-1:0]     wr_link;
	logic [EW-1:0]     tbl_rdata;

	logic              stk_we;
	logic [SW-1:0]     stk_waddr, stk_wdata, stk_raddr, stk_rdata;

	logic [OFF_W-1:0]  rd_off, rd_bytes;
	logic              rd_free;
	logic [LW-1:0]     rd_link;

	logic              res_v;
	logic [STAT_W-1:0] res_st;
	logic [ADDR_W-1:0] res_addr;

	logic [SIZE_W-1:0] req_size;
	logic [ADDR_W-1:0] pay_rd, pay_e;
	logic [OFF_W-1:0]  merged_bytes;
	logic fit, do_split, spare_ok, rd_end, walk_last, addr_hit, mrg, merge_last;

	ffha_ram #(.WIDTH(EW), .DEPTH(MAX_BLOCKS)) u_tbl (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (tbl_waddr),
		.wdata ({wr_off, wr_bytes, wr_free, wr_link}),
		.raddr (tbl_raddr),
		.rdata (tbl_rdata)
	);

	ffha_ram #(.WIDTH(SW), .DEPTH(MAX_BLOCKS)) u_stk (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	always_comb begin
		if (rd_head_q && !head_valid_q) begin
			rd_off   = '0;
			rd_bytes = HEAD_SZ;
			rd_free  = 1'b1;
			rd_link  = NULL_LINK;
		end else begin
			{rd_off, rd_bytes, rd_free, rd_link} = tbl_rdata;
		end
	end

	assign req_size     = (SIZE_W'(request_bytes) + SIZE_W'(7)) & ~SIZE_W'(7);
	assign fit          = rd_free && (SIZE_W'(rd_bytes) >= size_q);
	assign spare_ok     = (sp_q != '0) || (next_new_q < NULL_LINK);
	assign do_split     = fit && (SIZE_W'(rd_bytes) >= split_q) && spare_ok;
	assign rd_end       = rd_link >= NULL_LINK;
	assign walk_last    = (guard_q + GW'(1)) == WALK_LIM;
	assign pay_rd       = HEAP_BASE + ADDR_W'(rd_off) + ADDR_W'(HDR);
	assign pay_e        = HEAP_BASE + ADDR_W'(e_off_q) + ADDR_W'(HDR);
	assign addr_hit     = pay_rd == addr_q;
	assign mrg          = e_free_q && rd_free;
	assign merge_last   = rd_end || ((guard_q + GW'(1)) == MRG_LIM);
	assign merged_bytes = e_bytes_q + rd_bytes + HDR;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (kind == KIND_ALLOC) begin
						state_d = ST_A_CHK;
					end else if (free_address != '0) begin
						state_d = ST_F_CHK;
					end
				end
			end
			ST_A_CHK: begin
				if (fit) begin
					if (!do_split) begin
						state_d = ST_IDLE;
					end else if (sp_q != '0) begin
						state_d = ST_A_POP;
					end else begin
						state_d = ST_A_SPL;
					end
				end else if (rd_end || walk_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_A_POP:  state_d = ST_A_SPL;
			ST_A_SPL:  state_d = ST_A_FIN;
			ST_A_FIN:  state_d = ST_IDLE;
			ST_F_CHK: begin
				if (addr_hit) begin
					state_d = ST_M_HEAD;
				end else if (rd_end || walk_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_M_HEAD: state_d = ST_M_CUR;
			ST_M_CUR:  state_d = rd_end ? ST_IDLE : ST_M_NXT;
			ST_M_NXT: begin
				if (merge_last) begin
					state_d = ST_IDLE;
				end
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		tbl_raddr = rd_link[SW-1:0];
		tbl_we    = 1'b0;
		tbl_waddr = cur_q;
		wr_off    = rd_off;
		wr_bytes  = rd_bytes;
		wr_free   = rd_free;
		wr_link   = rd_link;
		stk_we    = 1'b0;
		stk_waddr = sp_q[SW-1:0];
		stk_wdata = e_link_q[SW-1:0];
		stk_raddr = SW'(sp_q - LW'(1));
		res_v     = 1'b0;
		res_st    = STAT_OK;
		res_addr  = '0;
		case (state_q)
			ST_IDLE: begin
				tbl_raddr = '0;
				if (start && kind == KIND_FREE && free_address == '0) begin
					res_v  = 1'b1;
					res_st = STAT_NULL;
				end
			end
			ST_A_CHK: begin
				if (fit && !do_split) begin
					tbl_we   = 1'b1;
					wr_free  = 1'b0;
					res_v    = 1'b1;
					res_addr = pay_rd;
				end else if (!fit && (rd_end || walk_last)) begin
					res_v  = 1'b1;
					res_st = STAT_NOMEM;
				end
			end
			ST_A_SPL: begin
				tbl_we    = 1'b1;
				tbl_waddr = ns_q;
				wr_off    = e_off_q + HDR + size_q[OFF_W-1:0];
				wr_bytes  = e_bytes_q - size_q[OFF_W-1:0] - HDR;
				wr_free   = 1'b1;
				wr_link   = e_link_q;
			end
			ST_A_FIN: begin
				tbl_we   = 1'b1;
				wr_off   = e_off_q;
				wr_bytes = size_q[OFF_W-1:0];
				wr_free  = 1'b0;
				wr_link  = LW'(ns_q);
				res_v    = 1'b1;
				res_addr = pay_e;
			end
			ST_F_CHK: begin
				if (addr_hit) begin
					tbl_we  = 1'b1;
					wr_free = 1'b1;
				end else if (rd_end || walk_last) begin
					res_v  = 1'b1;
					res_st = STAT_UNKNOWN;
				end
			end
			ST_M_HEAD: tbl_raddr = '0;
			ST_M_CUR: begin
				if (rd_end) begin
					res_v = 1'b1;
				end
			end
			ST_M_NXT: begin
				if (mrg) begin
					tbl_we   = 1'b1;
					wr_off   = e_off_q;
					wr_bytes = merged_bytes;
					wr_free  = 1'b1;
					wr_link  = rd_link;
					stk_we   = 1'b1;
				end
				if (merge_last) begin
					res_v = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			sp_q            <= '0;
			next_new_q      <= LW'(1);
			head_valid_q    <= 1'b0;
			rd_head_q       <= 1'b0;
			done            <= 1'b0;
			status          <= STAT_OK;
			payload_address <= '0;
		end else begin
			state_q   <= state_d;
			rd_head_q <= tbl_raddr == '0;
			done      <= res_v;
			if (res_v) begin
				status          <= res_st;
				payload_address <= res_addr;
			end
			if (tbl_we && tbl_waddr == '0) begin
				head_valid_q <= 1'b1;
			end
			if (state_q == ST_A_CHK && do_split && sp_q == '0) begin
				next_new_q <= next_new_q + LW'(1);
			end
			if (state_q == ST_A_POP) begin
				sp_q <= sp_q - LW'(1);
			end
			if (state_q == ST_M_NXT && mrg) begin
				sp_q <= sp_q + LW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				size_q  <= req_size;
				split_q <= req_size + HDR_S + SIZE_W'(8);
				addr_q  <= free_address;
				cur_q   <= '0;
				guard_q <= '0;
			end
			ST_A_CHK: begin
				if (fit) begin
					e_off_q   <= rd_off;
					e_bytes_q <= rd_bytes;
					e_free_q  <= rd_free;
					e_link_q  <= rd_link;
					ns_q      <= next_new_q[SW-1:0];
				end else begin
					cur_q   <= rd_link[SW-1:0];
					guard_q <= guard_q + GW'(1);
				end
			end
			ST_A_POP: ns_q <= stk_rdata;
			ST_F_CHK: begin
				if (!addr_hit) begin
					cur_q   <= rd_link[SW-1:0];
					guard_q <= guard_q + GW'(1);
				end
			end
			ST_M_CUR: begin
				e_off_q   <= rd_off;
				e_bytes_q <= rd_bytes;
				e_free_q  <= rd_free;
				e_link_q  <= rd_link;
				cur_q     <= '0;
				guard_q   <= '0;
			end
			ST_M_NXT: begin
				guard_q <= guard_q + GW'(1);
				if (mrg) begin
					e_bytes_q <= merged_bytes;
					e_link_q  <= rd_link;
				end else begin
					cur_q     <= e_link_q[SW-1:0];
					e_off_q   <= rd_off;
					e_bytes_q <= rd_bytes;
					e_free_q  <= rd_free;
					e_link_q  <= rd_link;
				end
			end
			default: ;
		endcase
	end

	assign busy = state_q != ST_IDLE;
endmodule
`default_nettype wire
